/* hw/rtl/rwl_pkg.sv */
// Shared types, constants and helpers for the FIFO readers/writers lock unit.
package rwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 4;
    localparam int QIDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int READER_BITS = 5;
    localparam int READER_MAX  = (1 << READER_BITS) - 1;

    localparam int CMDQ_DEPTH     = 2;
    localparam int CMDQ_IDX_BITS  = 1;
    localparam int CMDQ_CNT_BITS  = 2;

    typedef enum logic [1:0] {
        CMD_REQ_READ  = 2'd0,
        CMD_REQ_WRITE = 2'd1,
        CMD_REL_READ  = 2'd2,
        CMD_REL_WRITE = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        KIND_GRANTED   = 3'd0,
        KIND_QUEUED    = 3'd1,
        KIND_RELEASED  = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_REL_ERROR = 3'd4
    } kind_t;

    // A decoded command word as it travels from the front to the back.
    typedef struct packed {
        logic               unlock;
        logic               write;
        logic [ID_BITS-1:0] id;
    } word_t;

    // One entry of the wait queue.
    typedef struct packed {
        logic               writer;
        logic [ID_BITS-1:0] id;
    } entry_t;

    function automatic logic [QIDX_BITS-1:0] next_idx(input logic [QIDX_BITS-1:0] idx);
        logic [QIDX_BITS-1:0] res;
        if (idx == QIDX_BITS'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + QIDX_BITS'(1);
        end
        return res;
    endfunction

endpackage

/* hw/rtl/rwl_front.sv */
// Front end: accepts command words, decodes them and holds them in a short queue.
module rwl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [rwl_pkg::ID_BITS-1:0] requester_id,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output rwl_pkg::word_t              cmd_word
);

    rwl_pkg::word_t                      q_reg [rwl_pkg::CMDQ_DEPTH];
    logic [rwl_pkg::CMDQ_IDX_BITS-1:0]   wr_ptr_reg;
    logic [rwl_pkg::CMDQ_IDX_BITS-1:0]   wr_ptr_next;
    logic [rwl_pkg::CMDQ_IDX_BITS-1:0]   rd_ptr_reg;
    logic [rwl_pkg::CMDQ_IDX_BITS-1:0]   rd_ptr_next;
    logic [rwl_pkg::CMDQ_CNT_BITS-1:0]   cnt_reg;
    logic [rwl_pkg::CMDQ_CNT_BITS-1:0]   cnt_next;
    logic                                push;
    logic                                pop;
    rwl_pkg::word_t                      decoded;

    always_comb
    begin
        decoded.id = requester_id;
        case (rwl_pkg::cmd_code_t'(cmd))
            rwl_pkg::CMD_REQ_READ:
            begin
                decoded.unlock = 1'b0;
                decoded.write  = 1'b0;
            end
            rwl_pkg::CMD_REQ_WRITE:
            begin
                decoded.unlock = 1'b0;
                decoded.write  = 1'b1;
            end
            rwl_pkg::CMD_REL_READ:
            begin
                decoded.unlock = 1'b1;
                decoded.write  = 1'b0;
            end
            default:
            begin
                decoded.unlock = 1'b1;
                decoded.write  = 1'b1;
            end
        endcase
    end

    assign in_ready  = (cnt_reg != rwl_pkg::CMDQ_CNT_BITS'(rwl_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_word  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + rwl_pkg::CMDQ_IDX_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + rwl_pkg::CMDQ_IDX_BITS'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + rwl_pkg::CMDQ_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - rwl_pkg::CMDQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* hw/rtl/rwl_back.sv */
// Back end: lock state, wait queue memory, hand-off sequencer and output register.
module rwl_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  rwl_pkg::word_t              cmd_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  kind,
    output logic [rwl_pkg::ID_BITS-1:0] target_id,
    output logic                        as_writer,
    output logic                        last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_GRANT
    } state_t;

    state_t                              state_reg, state_next;
    logic [rwl_pkg::READER_BITS-1:0]     rc_reg, rc_next;
    logic                                writer_reg, writer_next;
    logic [rwl_pkg::QIDX_BITS-1:0]       head_reg, head_next;
    logic [rwl_pkg::QIDX_BITS-1:0]       tail_reg, tail_next;
    logic [rwl_pkg::QCNT_BITS-1:0]       qcnt_reg, qcnt_next;
    logic                                out_valid_reg, out_valid_next;
    rwl_pkg::kind_t                      kind_reg, kind_next;
    logic [rwl_pkg::ID_BITS-1:0]         id_reg, id_next;
    logic                                wr_reg, wr_next;
    logic                                last_reg, last_next;

    rwl_pkg::entry_t                     mem [rwl_pkg::QUEUE_DEPTH];
    rwl_pkg::entry_t                     rd0_reg;
    rwl_pkg::entry_t                     rd1_reg;
    logic                                mem_we;
    rwl_pkg::entry_t                     mem_wdata;
    logic [rwl_pkg::QIDX_BITS-1:0]       rd_addr1;

    logic                                out_free;
    logic                                must_wait;
    logic                                hand_off;
    logic                                more;

    assign out_free  = !out_valid_reg || out_ready;
    assign rd_addr1  = rwl_pkg::next_idx(head_next);

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign target_id = id_reg;
    assign as_writer = wr_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        rc_next        = rc_reg;
        writer_next    = writer_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        qcnt_next      = qcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        id_next        = id_reg;
        wr_next        = wr_reg;
        last_next      = last_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = '{writer: cmd_word.write, id: cmd_word.id};
        must_wait      = 1'b0;
        hand_off       = 1'b0;
        more           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready      = 1'b1;
                    out_valid_next = 1'b1;
                    id_next        = cmd_word.id;
                    wr_next        = cmd_word.write;
                    if (!cmd_word.unlock)
                    begin
                        if (!cmd_word.write)
                        begin
                            if (!writer_reg && qcnt_reg == '0 &&
                                rc_reg != rwl_pkg::READER_BITS'(rwl_pkg::READER_MAX))
                            begin
                                rc_next   = rc_reg + rwl_pkg::READER_BITS'(1);
                                kind_next = rwl_pkg::KIND_GRANTED;
                            end
                            else
                            begin
                                must_wait = 1'b1;
                            end
                        end
                        else
                        begin
                            if (!writer_reg && rc_reg == '0)
                            begin
                                writer_next = 1'b1;
                                kind_next   = rwl_pkg::KIND_GRANTED;
                            end
                            else
                            begin
                                must_wait = 1'b1;
                            end
                        end
                        if (must_wait)
                        begin
                            if (qcnt_reg == rwl_pkg::QCNT_BITS'(rwl_pkg::QUEUE_DEPTH))
                            begin
                                kind_next = rwl_pkg::KIND_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = rwl_pkg::next_idx(tail_reg);
                                qcnt_next = qcnt_reg + rwl_pkg::QCNT_BITS'(1);
                                kind_next = rwl_pkg::KIND_QUEUED;
                            end
                        end
                    end
                    else if (!cmd_word.write)
                    begin
                        if (rc_reg == '0)
                        begin
                            kind_next = rwl_pkg::KIND_REL_ERROR;
                        end
                        else
                        begin
                            rc_next   = rc_reg - rwl_pkg::READER_BITS'(1);
                            kind_next = rwl_pkg::KIND_RELEASED;
                            hand_off  = (rc_reg == rwl_pkg::READER_BITS'(1));
                        end
                    end
                    else
                    begin
                        if (!writer_reg)
                        begin
                            kind_next = rwl_pkg::KIND_REL_ERROR;
                        end
                        else
                        begin
                            writer_next = 1'b0;
                            kind_next   = rwl_pkg::KIND_RELEASED;
                            hand_off    = 1'b1;
                        end
                    end
                    if (hand_off && qcnt_reg != '0)
                    begin
                        last_next  = 1'b0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        last_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = rwl_pkg::KIND_GRANTED;
                    id_next        = rd0_reg.id;
                    wr_next        = rd0_reg.writer;
                    head_next      = rwl_pkg::next_idx(head_reg);
                    qcnt_next      = qcnt_reg - rwl_pkg::QCNT_BITS'(1);
                    if (rd0_reg.writer)
                    begin
                        writer_next = 1'b1;
                        last_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rc_next   = rc_reg + rwl_pkg::READER_BITS'(1);
                        more      = (qcnt_reg > rwl_pkg::QCNT_BITS'(1)) && !rd1_reg.writer &&
                                    (rc_reg < rwl_pkg::READER_BITS'(rwl_pkg::READER_MAX - 1));
                        last_next = !more;
                        state_next = more ? S_GRANT : S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rc_reg        <= '0;
            writer_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= rwl_pkg::KIND_GRANTED;
            id_reg        <= '0;
            wr_reg        <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rc_reg        <= rc_next;
            writer_reg    <= writer_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            wr_reg        <= wr_next;
            last_reg      <= last_next;
        end
    end

    // The head and the entry behind it are read every cycle at the next head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= mem_wdata;
        end
        rd0_reg <= mem[head_next];
        rd1_reg <= mem[rd_addr1];
    end

endmodule

/* hw/rtl/fifo_readers_writers_lock_unit.sv */
// Top level of the FIFO readers/writers lock unit: front decoder queue and back executor.
// A new word is held in the front queue, then in the back output register. Throughput:
// one command per cycle while the output is free; a hand-off reads the wait queue in a
// fetch state, then gives one grant per cycle while the output is free, taking no command.
// Reset: rst_n clears the lock state, queue pointers and valid flags; the wait queue
// memory is not cleared, as only written entries are ever read.
module fifo_readers_writers_lock_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [rwl_pkg::ID_BITS-1:0] requester_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  kind,
    output logic [rwl_pkg::ID_BITS-1:0] target_id,
    output logic                        as_writer,
    output logic                        last
);

    logic           cmd_valid;
    logic           cmd_ready;
    rwl_pkg::word_t cmd_word;

    rwl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .requester_id (requester_id),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_word     (cmd_word)
    );

    rwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .target_id (target_id),
        .as_writer (as_writer),
        .last      (last)
    );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the FIFO readers/writers lock unit, with its own lock predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rwl_pkg::ID_BITS-1:0] id_t;

    typedef struct {
        rwl_pkg::kind_t resp_kind;
        id_t            resp_id;
        logic           resp_writer;
        logic           resp_last;
    } lock_response_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [1:0] cmd          = rwl_pkg::CMD_REQ_READ;
    id_t        requester_id = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [2:0] kind;
    id_t        target_id;
    logic       as_writer;
    logic       last;

    // Predicted lock state.
    int              readers_holding = 0;
    logic            writer_holding  = 1'b0;
    rwl_pkg::entry_t waiting_line[$];
    lock_response_t  step_responses[$];
    lock_response_t  responses_due[$];

    int   mismatches        = 0;
    int   words_sent        = 0;
    int   responses_checked = 0;
    int   handoff_grants    = 0;
    int   full_rejections   = 0;
    int   burst_left        = 0;
    logic [7:0] ready_pattern = 8'hFF;
    int   pattern_age       = 0;

    fifo_readers_writers_lock_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .requester_id (requester_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .target_id    (target_id),
        .as_writer    (as_writer),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void add_response(input rwl_pkg::kind_t k, input id_t id, input logic wr);
        lock_response_t r;
        r.resp_kind   = k;
        r.resp_id     = id;
        r.resp_writer = wr;
        r.resp_last   = 1'b0;
        step_responses.push_back(r);
    endfunction

    function automatic void join_waiting_line(input id_t id, input logic wr);
        rwl_pkg::entry_t e;
        if (waiting_line.size() >= rwl_pkg::QUEUE_DEPTH)
        begin
            full_rejections++;
            add_response(rwl_pkg::KIND_FULL, id, wr);
        end
        else
        begin
            e.writer = wr;
            e.id     = id;
            waiting_line.push_back(e);
            add_response(rwl_pkg::KIND_QUEUED, id, wr);
        end
    endfunction

    // The head writer alone, or the run of readers at the head up to READER_MAX holders, takes the lock.
    function automatic void grant_waiting_head();
        rwl_pkg::entry_t e;
        if (waiting_line.size() == 0)
        begin
            return;
        end
        if (waiting_line[0].writer)
        begin
            e = waiting_line.pop_front();
            writer_holding = 1'b1;
            handoff_grants++;
            add_response(rwl_pkg::KIND_GRANTED, e.id, 1'b1);
        end
        else
        begin
            while (waiting_line.size() > 0 && readers_holding < rwl_pkg::READER_MAX
                   && !waiting_line[0].writer)
            begin
                e = waiting_line.pop_front();
                readers_holding++;
                handoff_grants++;
                add_response(rwl_pkg::KIND_GRANTED, e.id, 1'b0);
            end
        end
    endfunction

    function automatic void apply_lock_command(input rwl_pkg::cmd_code_t c, input id_t id);
        lock_response_t r;
        step_responses.delete();
        case (c)
            rwl_pkg::CMD_REQ_READ:
            begin
                if (!writer_holding && waiting_line.size() == 0
                    && readers_holding < rwl_pkg::READER_MAX)
                begin
                    readers_holding++;
                    add_response(rwl_pkg::KIND_GRANTED, id, 1'b0);
                end
                else
                begin
                    join_waiting_line(id, 1'b0);
                end
            end
            rwl_pkg::CMD_REQ_WRITE:
            begin
                if (!writer_holding && readers_holding == 0)
                begin
                    writer_holding = 1'b1;
                    add_response(rwl_pkg::KIND_GRANTED, id, 1'b1);
                end
                else
                begin
                    join_waiting_line(id, 1'b1);
                end
            end
            rwl_pkg::CMD_REL_READ:
            begin
                if (readers_holding == 0)
                begin
                    add_response(rwl_pkg::KIND_REL_ERROR, id, 1'b0);
                end
                else
                begin
                    readers_holding--;
                    add_response(rwl_pkg::KIND_RELEASED, id, 1'b0);
                    if (readers_holding == 0)
                    begin
                        grant_waiting_head();
                    end
                end
            end
            default:
            begin
                if (!writer_holding)
                begin
                    add_response(rwl_pkg::KIND_REL_ERROR, id, 1'b1);
                end
                else
                begin
                    writer_holding = 1'b0;
                    add_response(rwl_pkg::KIND_RELEASED, id, 1'b1);
                    grant_waiting_head();
                end
            end
        endcase
        for (int i = 0; i < step_responses.size(); i++)
        begin
            r = step_responses[i];
            r.resp_last = (i == step_responses.size() - 1);
            responses_due.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_response();
        lock_response_t want;
        if (responses_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d id %0d writer %0b last %0b",
                                      kind, target_id, as_writer, last));
            return;
        end
        want = responses_due.pop_front();
        responses_checked++;
        if (kind !== want.resp_kind)
        begin
            report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.resp_kind));
        end
        if (target_id !== want.resp_id)
        begin
            report_mismatch($sformatf("target_id %0d, wanted %0d", target_id, want.resp_id));
        end
        if (as_writer !== want.resp_writer)
        begin
            report_mismatch($sformatf("as_writer %0b, wanted %0b", as_writer, want.resp_writer));
        end
        if (last !== want.resp_last)
        begin
            report_mismatch($sformatf("last %0b, wanted %0b", last, want.resp_last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_response();
            end
            if (pattern_age == 0)
            begin
                pattern_age   = $urandom_range(16, 96);
                ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
            end
            pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            out_ready <= ready_pattern[0];
        end
    end

    task automatic send_command(input rwl_pkg::cmd_code_t c, input id_t id);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        requester_id <= id;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        words_sent++;
        apply_lock_command(c, id);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (responses_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic release_all_holders();
        while (writer_holding || readers_holding > 0 || waiting_line.size() > 0)
        begin
            if (writer_holding)
            begin
                send_command(rwl_pkg::CMD_REL_WRITE, id_t'($urandom_range(0, 15)));
            end
            else if (readers_holding > 0)
            begin
                send_command(rwl_pkg::CMD_REL_READ, id_t'($urandom_range(0, 15)));
            end
            else
            begin
                break;
            end
        end
    endtask

    task automatic test_basic_commands();
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(0));
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(15));
        send_command(rwl_pkg::CMD_REQ_WRITE, id_t'(5));
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(3));
        send_command(rwl_pkg::CMD_REL_WRITE, id_t'(9));
        send_command(rwl_pkg::CMD_REL_READ,  id_t'(0));
        send_command(rwl_pkg::CMD_REL_READ,  id_t'(15));
        send_command(rwl_pkg::CMD_REL_READ,  id_t'(1));
        send_command(rwl_pkg::CMD_REQ_WRITE, id_t'(10));
        send_command(rwl_pkg::CMD_REL_WRITE, id_t'(5));
        send_command(rwl_pkg::CMD_REL_READ,  id_t'(3));
        send_command(rwl_pkg::CMD_REL_WRITE, id_t'(10));
        release_all_holders();
        wait_drained();
    endtask

    task automatic test_queue_full();
        send_command(rwl_pkg::CMD_REQ_WRITE, id_t'(7));
        for (int i = 0; i < rwl_pkg::QUEUE_DEPTH; i++)
        begin
            send_command(rwl_pkg::CMD_REQ_READ, id_t'(i));
        end
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(15));
        send_command(rwl_pkg::CMD_REQ_WRITE, id_t'(0));
        send_command(rwl_pkg::CMD_REL_WRITE, id_t'(7));
        release_all_holders();
        wait_drained();
    endtask

    task automatic test_reader_saturation();
        for (int i = 0; i < rwl_pkg::READER_MAX; i++)
        begin
            send_command(rwl_pkg::CMD_REQ_READ, id_t'(i % 16));
        end
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(12));
        send_command(rwl_pkg::CMD_REQ_WRITE, id_t'(6));
        send_command(rwl_pkg::CMD_REQ_READ,  id_t'(2));
        release_all_holders();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int                 sel;
        rwl_pkg::cmd_code_t c;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                c = rwl_pkg::cmd_code_t'($urandom_range(0, 3));
            end
            else if (sel < 45)
            begin
                c = rwl_pkg::CMD_REQ_READ;
            end
            else if (sel < 65)
            begin
                c = rwl_pkg::CMD_REQ_WRITE;
            end
            else if (writer_holding)
            begin
                c = rwl_pkg::CMD_REL_WRITE;
            end
            else if (readers_holding > 0)
            begin
                c = rwl_pkg::CMD_REL_READ;
            end
            else
            begin
                c = rwl_pkg::CMD_REQ_WRITE;
            end
            send_command(c, id_t'($urandom_range(0, 15)));
            if (n % 80 == 79)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_commands();
        test_queue_full();
        test_reader_saturation();
        test_random_traffic(200);
        if (responses_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", responses_due.size()));
        end
        $display("Sent %0d command words and checked %0d result words.",
                 words_sent, responses_checked);
        $display("Covered %0d hand-off grants, %0d queue-full rejections and reader saturation.",
                 handoff_grants, full_rejections);
        if (mismatches == 0)
        begin
            $display("** fifo_readers_writers_lock_unit: PASSED **");
        end
        else
        begin
            $display("** fifo_readers_writers_lock_unit: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Timed out with %0d results outstanding.", responses_due.size());
        $display("** fifo_readers_writers_lock_unit: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rwl_pkg.sv
hw/rtl/rwl_front.sv
hw/rtl/rwl_back.sv
hw/rtl/fifo_readers_writers_lock_unit.sv
bench/testbench.sv
